// ===== hw/rtl/dlcaf_pkg.sv =====
// ============================================================================
// Delay-line filter package
// Shared widths, register codes, handshake structs and the saturation helper
// for the comb, slapback and allpass delay-line filter.
// ============================================================================
package dlcaf_pkg;

    // Sample and delay memory geometry. The memory depth must be a power of
    // two so that the pointers wrap on their own.
    localparam int SAMPLE_BITS  = 24;
    localparam int BUFFER_DEPTH = 32768;
    localparam int ADDR_BITS    = $clog2(BUFFER_DEPTH);

    // Register field widths.
    localparam int MODE_BITS  = 2;
    localparam int DELAY_BITS = 15;
    localparam int GAIN_BITS  = 16;
    localparam int FRAC_BITS  = 14;

    // Arithmetic widths: full product, rounded product and the sum headroom.
    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam int RND_BITS  = PROD_BITS - FRAC_BITS;
    localparam int ACC_BITS  = SAMPLE_BITS + 3;

    // Configuration channel.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Output queue.
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);
    localparam int OQ_SUM_BITS = OQ_CNT_BITS + 1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SLAPBACK    = 2'd0,
        MODE_COMB        = 2'd1,
        MODE_ALLPASS     = 2'd2,
        MODE_ALLPASS_ALT = 2'd3
    } filter_mode_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_DELAY = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_GAIN  = 2'd2;

    localparam filter_mode_t                  RST_MODE  = MODE_COMB;
    localparam logic [DELAY_BITS-1:0]         RST_DELAY = 15'd500;
    localparam logic signed [GAIN_BITS-1:0]   RST_GAIN  = 16'sd4915;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;

    typedef struct packed {
        filter_mode_t                filter_mode;
        logic [DELAY_BITS-1:0]       delay_samples;
        logic signed [GAIN_BITS-1:0] feedback_gain;
    } cfg_t;

    // One accepted sample entering the pipeline, with its memory addresses.
    typedef struct packed {
        logic    valid;
        sample_t x;
        addr_t   wr_addr;
        addr_t   rd_addr;
        logic    rd_ok;
    } issue_t;

    typedef struct packed {
        logic    en;
        addr_t   addr;
        sample_t data;
    } mem_wr_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } pipe_status_t;

    // Clamp a wide signed sum to the signed sample range.
    function automatic sample_t sat_sample(input logic signed [ACC_BITS-1:0] v);
        logic over_hi;
        logic over_lo;
        over_hi = !v[ACC_BITS-1] && (|v[ACC_BITS-2:SAMPLE_BITS-1]);
        over_lo = v[ACC_BITS-1] && !(&v[ACC_BITS-2:SAMPLE_BITS-1]);
        if (over_hi)
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (over_lo)
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/dlcaf_if.sv =====
// ============================================================================
// Delay-line filter channel interfaces
// Valid/ready channels for input samples, output samples and register writes.
// ============================================================================
interface dlcaf_in_if import dlcaf_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dlcaf_out_if import dlcaf_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface dlcaf_cfg_if import dlcaf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dlcaf_ram.sv =====
// ============================================================================
// Generic single-clock RAM
// One write port and one read port, registered read data, read-first when
// both ports address the same entry in the same cycle.
// ============================================================================
module dlcaf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/dlcaf_cfg_regs.sv =====
// ============================================================================
// Delay-line filter configuration registers
// Decodes register write beats into mode, delay and gain; unknown indexes
// are dropped.
// ============================================================================
module dlcaf_cfg_regs import dlcaf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    dlcaf_cfg_if.sink         cfg,
    output cfg_t              cfg_q
);

    cfg_t regs_reg;
    cfg_t regs_next;
    logic wr_fire;

    assign cfg.ready = 1'b1;
    assign wr_fire   = cfg.valid && cfg.ready;
    assign cfg_q     = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_fire)
        begin
            unique case (cfg.index)
                CFG_IDX_MODE:  regs_next.filter_mode   = filter_mode_t'(cfg.data[MODE_BITS-1:0]);
                CFG_IDX_DELAY: regs_next.delay_samples = cfg.data[DELAY_BITS-1:0];
                CFG_IDX_GAIN:  regs_next.feedback_gain = cfg.data[GAIN_BITS-1:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.filter_mode   <= RST_MODE;
            regs_reg.delay_samples <= RST_DELAY;
            regs_reg.feedback_gain <= RST_GAIN;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hw/rtl/dlcaf_datapath.sv =====
// ============================================================================
// Delay-line filter datapath
// Two stages after the memory read: gain products, then rounding, sums,
// saturation and write-back of the new delay value.
// ============================================================================
module dlcaf_datapath import dlcaf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  issue_t       issue,
    input  sample_t      rd_data,
    output mem_wr_t      wr,
    output pipe_status_t status,
    output logic         res_push,
    output sample_t      res_data
);

    // Stage 1: memory data arrives.
    logic    s1_valid_reg;
    sample_t s1_x_reg;
    addr_t   s1_wr_addr_reg;
    addr_t   s1_rd_addr_reg;
    logic    s1_rd_ok_reg;

    // Last write, kept for the read that raced it.
    logic    fwd_en_reg;
    addr_t   fwd_addr_reg;
    sample_t fwd_data_reg;

    logic                        fwd_hit;
    sample_t                     s1_d;
    logic signed [GAIN_BITS-1:0] gain;
    logic signed [PROD_BITS-1:0] s1_gd;
    logic signed [PROD_BITS-1:0] s1_gx;

    // Stage 2: products registered.
    logic                        s2_valid_reg;
    sample_t                     s2_x_reg;
    sample_t                     s2_d_reg;
    addr_t                       s2_wr_addr_reg;
    logic signed [PROD_BITS-1:0] s2_gd_reg;
    logic signed [PROD_BITS-1:0] s2_gx_reg;

    logic signed [RND_BITS-1:0] gd_hi;
    logic signed [RND_BITS-1:0] gx_hi;
    logic signed [ACC_BITS-1:0] x_e;
    logic signed [ACC_BITS-1:0] d_e;
    logic signed [ACC_BITS-1:0] gd_e;
    logic signed [ACC_BITS-1:0] gx_e;
    logic signed [ACC_BITS-1:0] gd_rb;
    logic signed [ACC_BITS-1:0] gx_rb;
    logic signed [ACC_BITS-1:0] fb_sum;
    logic signed [ACC_BITS-1:0] ff_sum;
    logic signed [ACC_BITS-1:0] ap_diff;
    sample_t                    stored;
    sample_t                    y;

    // The write that lands on the same edge as a read is not seen by the
    // read-first memory, so it is taken from the forwarding register. Entries
    // never written since reset read as zero.
    assign fwd_hit = fwd_en_reg && (fwd_addr_reg == s1_rd_addr_reg);
    assign s1_d    = fwd_hit ? fwd_data_reg : (s1_rd_ok_reg ? rd_data : '0);
    assign gain    = cfg.feedback_gain;
    assign s1_gd   = gain * s1_d;
    assign s1_gx   = gain * s1_x_reg;

    // Rounding half up: floor(p / 2^14) plus the bit just below the cut.
    assign gd_hi  = s2_gd_reg[PROD_BITS-1:FRAC_BITS];
    assign gx_hi  = s2_gx_reg[PROD_BITS-1:FRAC_BITS];
    assign x_e    = ACC_BITS'(s2_x_reg);
    assign d_e    = ACC_BITS'(s2_d_reg);
    assign gd_e   = ACC_BITS'(gd_hi);
    assign gx_e   = ACC_BITS'(gx_hi);
    assign gd_rb  = {{(ACC_BITS-1){1'b0}}, s2_gd_reg[FRAC_BITS-1]};
    assign gx_rb  = {{(ACC_BITS-1){1'b0}}, s2_gx_reg[FRAC_BITS-1]};
    assign fb_sum  = x_e + gd_e + gd_rb;
    assign ff_sum  = x_e + d_e;
    assign ap_diff = d_e - gx_e - gx_rb;

    always_comb
    begin
        unique case (cfg.filter_mode)
            MODE_SLAPBACK:
            begin
                stored = s2_x_reg;
                y      = sat_sample(ff_sum);
            end
            MODE_COMB:
            begin
                stored = sat_sample(fb_sum);
                y      = sat_sample(ff_sum);
            end
            MODE_ALLPASS, MODE_ALLPASS_ALT:
            begin
                stored = sat_sample(fb_sum);
                y      = sat_sample(ap_diff);
            end
        endcase
    end

    assign wr.en    = s2_valid_reg;
    assign wr.addr  = s2_wr_addr_reg;
    assign wr.data  = stored;
    assign res_push = s2_valid_reg;
    assign res_data = y;

    assign status.s1_valid = s1_valid_reg;
    assign status.s2_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_en_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            s2_valid_reg <= s1_valid_reg;
            fwd_en_reg   <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg       <= issue.x;
        s1_wr_addr_reg <= issue.wr_addr;
        s1_rd_addr_reg <= issue.rd_addr;
        s1_rd_ok_reg   <= issue.rd_ok;

        s2_x_reg       <= s1_x_reg;
        s2_d_reg       <= s1_d;
        s2_wr_addr_reg <= s1_wr_addr_reg;
        s2_gd_reg      <= s1_gd;
        s2_gx_reg      <= s1_gx;

        fwd_addr_reg   <= s2_wr_addr_reg;
        fwd_data_reg   <= stored;
    end

    // Writes of back-to-back samples go to consecutive memory entries.
    a_wr_addr_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && $past(wr.en)) |-> (wr.addr == $past(wr.addr) + ADDR_BITS'(1)))
        else $error("delay memory writes are not in pointer order");

endmodule

// ===== hw/rtl/dlcaf_out_queue.sv =====
// ============================================================================
// Delay-line filter output queue
// Small register queue between the datapath and the result channel, so the
// pipeline keeps moving while the receiver stalls.
// ============================================================================
module dlcaf_out_queue import dlcaf_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sample_t                push_data,
    dlcaf_out_if.source            results,
    output logic [OQ_CNT_BITS-1:0] count
);

    sample_t                  mem_reg [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0]   wr_ptr_reg;
    logic [OQ_PTR_BITS-1:0]   wr_ptr_next;
    logic [OQ_PTR_BITS-1:0]   rd_ptr_reg;
    logic [OQ_PTR_BITS-1:0]   rd_ptr_next;
    logic [OQ_CNT_BITS-1:0]   count_reg;
    logic [OQ_CNT_BITS-1:0]   count_next;
    logic                     pop;

    assign results.valid      = (count_reg != '0);
    assign results.sample_out = mem_reg[rd_ptr_reg];
    assign pop                = results.valid && results.ready;
    assign count              = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OQ_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OQ_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + OQ_CNT_BITS'(push) - OQ_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The input credit check must keep a full queue from being pushed.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != OQ_CNT_BITS'(OQ_DEPTH)))
        else $error("output queue pushed while full");

endmodule

// ===== hw/rtl/delay_line_comb_allpass_filter_top.sv =====
// ============================================================================
// Delay-line comb / allpass filter, top level
// Slapback, feedback comb and Schroeder allpass on a circular delay memory.
// ============================================================================
// Usage:
//   samples : input beats, one signed 24-bit sample each.
//   results : output beats, one filtered sample for every input beat, in order.
//   cfg     : register writes (0 mode, 1 delay, 2 gain); write only while the
//             filter holds no sample in flight. Other indexes are ignored.
// Path: memory read, then products, then sums and saturation, then the queue.
// Throughput: one sample per cycle while the queue has room, set by one read and
// one write of the delay memory per sample. With a delay of one sample, each
// sample needs its predecessor's write-back and is never taken right behind it.
// Reset: pointer at zero, registers at mode comb, delay 500, gain 4915 (about
// 0.3). The delay memory is not swept: a lap marker on the write pointer makes
// every entry not yet written read as zero, so samples are taken right away.
// Stalls: results pass through a four-entry queue; samples ready drops as soon
// as the queue plus the samples still in the pipeline fill it, and no
// result is ever dropped.
// ============================================================================
module delay_line_comb_allpass_filter_top import dlcaf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    dlcaf_cfg_if.sink    cfg,
    dlcaf_in_if.sink     samples,
    dlcaf_out_if.source  results
);

    cfg_t                   cfg_q;
    issue_t                 issue;
    mem_wr_t                wr;
    pipe_status_t           status;
    sample_t                ram_rd_data;
    logic                   res_push;
    sample_t                res_data;
    logic [OQ_CNT_BITS-1:0] oq_count;
    logic [OQ_SUM_BITS-1:0] oq_need;
    logic                   credit_ok;
    logic                   short_delay;
    logic                   in_fire;

    addr_t wp_reg;
    addr_t wp_next;
    logic  wrapped_reg;
    logic  wrapped_next;
    addr_t back;
    addr_t rd_addr;

    dlcaf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Read point lies delay_samples behind the write pointer, modulo depth.
    assign back    = ADDR_BITS'(cfg_q.delay_samples);
    assign rd_addr = wp_reg - back;

    assign oq_need = OQ_SUM_BITS'(oq_count) + OQ_SUM_BITS'(status.s1_valid)
                   + OQ_SUM_BITS'(status.s2_valid) + OQ_SUM_BITS'(1);
    assign credit_ok   = (oq_need <= OQ_SUM_BITS'(OQ_DEPTH));
    assign short_delay = (back == ADDR_BITS'(1)) && status.s1_valid;

    assign samples.ready = credit_ok && !short_delay;
    assign in_fire       = samples.valid && samples.ready;

    assign issue.valid   = in_fire;
    assign issue.x       = samples.sample_in;
    assign issue.wr_addr = wp_reg;
    assign issue.rd_addr = rd_addr;
    // Before the first wrap only entries below the pointer hold written data.
    assign issue.rd_ok   = wrapped_reg || (rd_addr < wp_reg);

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (in_fire)
        begin
            wp_next = wp_reg + ADDR_BITS'(1);
            if (wp_reg == ADDR_BITS'(BUFFER_DEPTH - 1))
            begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

    dlcaf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_delay_mem (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    dlcaf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_q),
        .issue    (issue),
        .rd_data  (ram_rd_data),
        .wr       (wr),
        .status   (status),
        .res_push (res_push),
        .res_data (res_data)
    );

    dlcaf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .results   (results),
        .count     (oq_count)
    );

    // Every accepted sample pushes its result into the queue from stage 2.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> ##1 res_push)
        else $error("result not produced two cycles after its sample");

    // With a one-sample delay, a sample is never taken right behind another.
    a_short_delay_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && back == ADDR_BITS'(1)) |=> !in_fire)
        else $error("one-sample delay taken without a gap cycle");

    // Queue entries plus samples in the pipeline never exceed the queue size.
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (OQ_SUM_BITS'(oq_count) + OQ_SUM_BITS'(status.s1_valid)
         + OQ_SUM_BITS'(status.s2_valid)) <= OQ_SUM_BITS'(OQ_DEPTH))
        else $error("more samples in flight than output queue space");

endmodule

// ===== dv/dlcaf_filter_check.sv =====
// ============================================================================
// Delay-line filter output checker
// Watches the register, sample and result channels of the filter. It keeps its
// own delay memory, write pointer and register copies, predicts every output
// beat, and compares each accepted result beat with the oldest prediction.
// ============================================================================
module dlcaf_filter_check import dlcaf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    dlcaf_cfg_if cfg,
    dlcaf_in_if  samples,
    dlcaf_out_if results,
    output int   failures,
    output int   outstanding
);

    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    sample_t                     echo_mem [BUFFER_DEPTH];
    addr_t                       wr_ptr;
    filter_mode_t                mode_q;
    logic [DELAY_BITS-1:0]       delay_q;
    logic signed [GAIN_BITS-1:0] gain_q;
    sample_t                     filtered_q [$];
    sample_t                     next_y;
    sample_t                     want_y;
    int                          beat_no;

    function automatic sample_t clamp_sample(input longint v);
        if (v > SAT_HI)
            return sample_t'(SAT_HI);
        if (v < SAT_LO)
            return sample_t'(SAT_LO);
        return sample_t'(v);
    endfunction

    // Q2.14 gain times a sample, rounded half up onto the sample grid.
    function automatic longint gain_scale(input logic signed [GAIN_BITS-1:0] g,
                                          input longint v);
        longint p;
        p = longint'(g) * v + (64'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    task automatic filter_step(input sample_t x_in, output sample_t y);
        longint x;
        longint d;
        longint stored;
        addr_t  rd;
        x = longint'(x_in);
        // The subtraction wraps at the memory depth; a delay of zero reads the
        // entry that is about to be overwritten.
        rd = wr_ptr - addr_t'(delay_q);
        d = longint'(echo_mem[rd]);
        if (mode_q == MODE_SLAPBACK) begin
            stored = x;
            y = clamp_sample(x + d);
        end
        else begin
            stored = clamp_sample(x + gain_scale(gain_q, d));
            if (mode_q == MODE_COMB)
                y = clamp_sample(x + d);
            else
                y = clamp_sample(d - gain_scale(gain_q, x));
        end
        echo_mem[wr_ptr] = sample_t'(stored);
        wr_ptr = wr_ptr + addr_t'(1);
    endtask

    task automatic report_mismatch(input string msg);
        failures++;
        $display("[%0t] dlcaf mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++)
                echo_mem[addr_t'(i)] = '0;
            wr_ptr = '0;
            mode_q = RST_MODE;
            delay_q = RST_DELAY;
            gain_q = RST_GAIN;
            filtered_q.delete();
            beat_no = 0;
            failures = 0;
            outstanding = 0;
        end
        else begin
            // Results are checked first so that a stray beat never matches a
            // sample taken on the same edge.
            if (results.valid === 1'b1 && results.ready === 1'b1) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d (%0d) with no sample pending",
                                              beat_no, results.sample_out));
                end
                else begin
                    want_y = filtered_q.pop_front();
                    if (results.sample_out !== want_y)
                        report_mismatch($sformatf("result beat %0d sample_out %0d, predicted %0d",
                                                  beat_no, results.sample_out, want_y));
                end
                beat_no++;
            end
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
                case (cfg.index)
                    CFG_IDX_MODE:  mode_q = filter_mode_t'(cfg.data[MODE_BITS-1:0]);
                    CFG_IDX_DELAY: delay_q = cfg.data[DELAY_BITS-1:0];
                    CFG_IDX_GAIN:  gain_q = cfg.data;
                    default: ;
                endcase
            end
            if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
                filter_step(samples.sample_in, next_y);
                filtered_q.push_back(next_y);
            end
            outstanding = filtered_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ============================================================================
// Delay-line filter testbench
// Drives samples and register writes into the filter with random gaps and
// result stalls, and lets the checker predict and compare every result beat.
// A short warm-up under the reset settings runs first.
// ============================================================================
module tb_top;
    import dlcaf_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SPARE = 2'd3;
    localparam sample_t                     S_MAX = 24'sh7FFFFF;
    localparam sample_t                     S_MIN = 24'sh800000;
    localparam logic [DELAY_BITS-1:0]       DELAY_MAX = 15'h7FFF;
    localparam logic signed [GAIN_BITS-1:0] GAIN_MAX = 16'sh7FFF;
    localparam logic signed [GAIN_BITS-1:0] GAIN_MIN = 16'sh8000;
    localparam logic signed [GAIN_BITS-1:0] GAIN_ONE = 16'sd16384;
    localparam int                          RUN_LIMIT = 2_000_000;
    localparam int                          PHASE_BEATS = 380;
    localparam int                          WARMUP_BEATS = 120;

    logic clk = 1'b0;
    logic rst_n;
    int   in_idle_pct;
    int   out_stall_pct;
    int   failures;
    int   outstanding;

    dlcaf_cfg_if cfg_ch ();
    dlcaf_in_if  in_ch ();
    dlcaf_out_if out_ch ();

    delay_line_comb_allpass_filter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (in_ch),
        .results (out_ch)
    );

    dlcaf_filter_check filter_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .samples     (in_ch),
        .results     (out_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial out_ch.ready = 1'b0;

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

    // Mix of full-scale noise, quieter signal and the range limits.
    function automatic sample_t rand_sample();
        int v;
        case ($urandom_range(3))
            0, 1: return sample_t'($urandom);
            2:
            begin
                v = $urandom_range(262143);
                return sample_t'(v - 131072);
            end
            default:
            begin
                case ($urandom_range(3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic push_sample(input sample_t x);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.sample_in <= sample_t'($urandom);
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= x;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every predicted beat has come back, plus the pipeline depth.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_filter(input filter_mode_t m, input logic [DELAY_BITS-1:0] dly,
                              input logic signed [GAIN_BITS-1:0] g);
        logic [CFG_DATA_BITS-1:0] pad;
        drain();
        // Unused upper data bits carry noise; the block must ignore them.
        pad = CFG_DATA_BITS'($urandom);
        write_reg(CFG_IDX_MODE, {pad[CFG_DATA_BITS-1:MODE_BITS], m});
        pad = CFG_DATA_BITS'($urandom);
        write_reg(CFG_IDX_DELAY, {pad[CFG_DATA_BITS-1:DELAY_BITS], dly});
        write_reg(CFG_IDX_GAIN, g);
    endtask

    task automatic randomize_filter();
        logic [DELAY_BITS-1:0]       dly;
        logic signed [GAIN_BITS-1:0] g;
        case ($urandom_range(9))
            0: dly = '0;
            1: dly = 15'd1;
            2: dly = DELAY_MAX;
            3, 4: dly = DELAY_BITS'($urandom_range(16, 2));
            default: dly = DELAY_BITS'($urandom);
        endcase
        case ($urandom_range(7))
            0: g = GAIN_MAX;
            1: g = GAIN_MIN;
            2: g = '0;
            3: g = GAIN_ONE;
            default: g = GAIN_BITS'($urandom);
        endcase
        set_filter(filter_mode_t'($urandom_range(3)), dly, g);
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_SPARE, CFG_DATA_BITS'($urandom));
    endtask

    initial
    begin
        int sent;
        int n;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Warm-up under the reset settings: these beats read entries not yet
        // written.
        repeat (WARMUP_BEATS) push_sample(rand_sample());

        set_filter(MODE_SLAPBACK, 15'd1, GAIN_MAX);
        push_sample(S_MAX);
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(S_MIN);
        push_sample('0);
        set_filter(MODE_COMB, 15'd1, GAIN_MAX);
        push_sample(S_MAX);
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(S_MIN);
        set_filter(MODE_ALLPASS, 15'd1, GAIN_MIN);
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(S_MIN);
        push_sample(S_MAX);
        // The spare mode code selects the allpass path.
        set_filter(MODE_ALLPASS_ALT, 15'd1, GAIN_MAX);
        push_sample(S_MIN);
        push_sample(S_MAX);
        push_sample('0);
        // Zero delay reads the entry at the write pointer before it is
        // overwritten.
        set_filter(MODE_COMB, '0, GAIN_ONE);
        push_sample(S_MAX);
        push_sample('1);
        set_filter(MODE_ALLPASS, DELAY_MAX, -GAIN_ONE);
        push_sample(24'sd1);
        push_sample(S_MIN);
        // A write to the unused index must leave every register alone.
        drain();
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        push_sample(S_MAX);
        push_sample(S_MIN);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct = 77;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 77;
                end
                default:
                begin
                    in_idle_pct = 18;
                    out_stall_pct = 18;
                end
            endcase
            sent = 0;
            while (sent < PHASE_BEATS) begin
                randomize_filter();
                n = $urandom_range(110, 40);
                repeat (n) push_sample(rand_sample());
                sent += n;
            end
        end

        drain();
        if (failures == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
